/* hdl/rle_sprite_packet_decoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// RLE sprite packet decoder - assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RLE_SPRITE_PACKET_DECODER_UNIT_DEFINES_SVH
`define RLE_SPRITE_PACKET_DECODER_UNIT_DEFINES_SVH

// Implication checked in the same cycle, off during reset
`define RSP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle, off during reset
`define RSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/rsp_pkg.sv */
// ----------------------------------------------------------------------------
// RLE sprite packet decoder - package
// Types, codes and sizes shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

	// Field widths
	localparam int BYTE_W      = 8;
	localparam int LINE_W      = 16;
	localparam int TOTAL_W     = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 1;
	localparam int FILL_W      = 17;
	localparam int RUN_W       = 8;
	localparam int LIT_W       = 7;

	// Default pixel counter size
	localparam int PIXEL_COUNT_BITS = 24;

	// Reset values of the configuration registers
	localparam logic [LINE_W-1:0]  LINE_WIDTH_RST   = 16'd320;
	localparam logic [TOTAL_W-1:0] TOTAL_PIXELS_RST = 24'd64000;

	// Header flag: set for a repeated-colour run
	localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;

	// Result queue depth
	localparam int RES_DEPTH = 4;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PIXELS = 1'b1;

	typedef enum logic [2:0] {
		KIND_SKIP  = 3'd0,
		KIND_SOLID = 3'd1,
		KIND_COPY  = 3'd2,
		KIND_PIXEL = 3'd3,
		KIND_NEXT  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [RUN_W-1:0]  run_length;
		logic [BYTE_W-1:0] pixel_value;
		logic              image_done;
		logic              last;
	} result_t;

	// Results caused by one input word
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

endpackage

`default_nettype wire

/* hdl/rsp_decode.sv */
// ----------------------------------------------------------------------------
// RLE sprite packet decoder - stream decoder
// Holds the run state and turns each accepted byte into zero to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_decode #(
	parameter int PIXEL_COUNT_BITS = rsp_pkg::PIXEL_COUNT_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_fire,
	input  wire logic [rsp_pkg::BYTE_W-1:0]      data_byte,
	input  wire logic [rsp_pkg::LINE_W-1:0]      line_width,
	input  wire logic [rsp_pkg::TOTAL_W-1:0]     total_pixels,
	output rsp_pkg::result_pair_t                res
);

	localparam int PIX_W  = PIXEL_COUNT_BITS + 1;
	localparam int PSUM_W = PIX_W + 1;
	localparam int FSUM_W = rsp_pkg::FILL_W + 1;
	localparam int WIDE_W = 33;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_COLOR  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [rsp_pkg::LIT_W-1:0]       lit_left_q, lit_left_d;
	logic [rsp_pkg::RUN_W-1:0]       run_q, run_d;
	logic [rsp_pkg::FILL_W-1:0]      fill_q, fill_d;
	logic [PIX_W-1:0]                pix_q, pix_d;

	logic [WIDE_W-1:0]               total_wide;
	logic [PIX_W-1:0]                total_cmp;
	logic                            done_now;
	logic                            marker;
	logic [rsp_pkg::FILL_W-1:0]      fill_base;
	logic [FSUM_W-1:0]               fill_sum;
	logic [rsp_pkg::FILL_W-1:0]      fill_new;
	logic [PSUM_W-1:0]               pix_sum;
	logic [PIX_W-1:0]                pix_new;
	logic                            done_new;

	// Mask the target to the counter size
	assign total_wide = WIDE_W'(total_pixels);
	assign total_cmp  = {1'b0, total_wide[PIXEL_COUNT_BITS-1:0]};
	assign done_now   = (pix_q >= total_cmp);

	// Close a run: line check, saturating fill and pixel counters
	assign marker    = (fill_q >= rsp_pkg::FILL_W'(line_width));
	assign fill_base = marker ? '0 : fill_q;
	assign fill_sum  = FSUM_W'(fill_base) + FSUM_W'(run_q);
	assign fill_new  = fill_sum[FSUM_W-1] ? '1 : fill_sum[rsp_pkg::FILL_W-1:0];
	assign pix_sum   = PSUM_W'(pix_q) + PSUM_W'(run_q);
	assign pix_new   = pix_sum[PSUM_W-1] ? '1 : pix_sum[PIX_W-1:0];
	assign done_new  = (pix_new >= total_cmp);

	// Decode one byte against the current phase
	always_comb begin
		phase_d    = phase_q;
		lit_left_d = lit_left_q;
		run_d      = run_q;
		fill_d     = fill_q;
		pix_d      = pix_q;
		res        = '0;
		res.r0.kind = rsp_pkg::KIND_SKIP;
		res.r1.kind = rsp_pkg::KIND_NEXT;
		res.r1.image_done = done_new;
		res.r1.last = 1'b1;

		unique case (phase_q)
			PH_COLOR: begin
				res.r0.kind        = (data_byte == '0) ? rsp_pkg::KIND_SKIP
					: rsp_pkg::KIND_SOLID;
				res.r0.run_length  = run_q;
				res.r0.pixel_value = data_byte;
				res.r0.image_done  = done_new;
				res.r0.last        = !marker;
				res.count          = marker ? 2'd2 : 2'd1;
				fill_d             = fill_new;
				pix_d              = pix_new;
				phase_d            = PH_HEADER;
			end
			PH_LITERAL: begin
				res.r0.kind        = rsp_pkg::KIND_PIXEL;
				res.r0.pixel_value = data_byte;
				if (lit_left_q == '0) begin
					res.r0.image_done = done_new;
					res.r0.last       = !marker;
					res.count         = marker ? 2'd2 : 2'd1;
					fill_d            = fill_new;
					pix_d             = pix_new;
					phase_d           = PH_HEADER;
				end else begin
					res.r0.last = 1'b1;
					res.count   = 2'd1;
					lit_left_d  = lit_left_q - 1'b1;
				end
			end
			default: begin
				phase_d = PH_HEADER;
				if (!done_now) begin
					run_d = rsp_pkg::RUN_W'(data_byte[rsp_pkg::LIT_W-1:0]) + 1'b1;
					if ((data_byte & rsp_pkg::RUN_FLAG) != '0) begin
						phase_d = PH_COLOR;
					end else begin
						lit_left_d        = data_byte[rsp_pkg::LIT_W-1:0];
						phase_d           = PH_LITERAL;
						res.r0.kind       = rsp_pkg::KIND_COPY;
						res.r0.run_length = run_d;
						res.r0.last       = 1'b1;
						res.count         = 2'd1;
					end
				end
			end
		endcase

		// Nothing leaves without an accepted word
		if (!in_fire) begin
			res.count = 2'd0;
		end
	end

	// Advance the decoder state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			lit_left_q <= '0;
			run_q      <= '0;
			fill_q     <= '0;
			pix_q      <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			lit_left_q <= lit_left_d;
			run_q      <= run_d;
			fill_q     <= fill_d;
			pix_q      <= pix_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/rsp_result_queue.sv */
// ----------------------------------------------------------------------------
// RLE sprite packet decoder - result queue
// Small register queue that takes up to two results a cycle and gives one on out_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_result_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rsp_pkg::result_pair_t push,
	output logic                       room,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output rsp_pkg::result_t           head
);

	localparam int DEPTH = rsp_pkg::RES_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rsp_pkg::result_t    slot_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W-1:0]    wr_ptr_nx;
	logic [CNT_W-1:0]    cnt_q;
	logic                pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	// Leave space for the two results a word can cause
	assign room = (cnt_q <= CNT_W'(DEPTH - 2));

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			slot_q[wr_ptr_nx] <= push.r1;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* hdl/rle_sprite_packet_decoder_unit.sv */
// ----------------------------------------------------------------------------
// RLE sprite packet decoder unit
// Turns an 8-bit run-length pixel byte stream into run and pixel packets.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word                         Handshake
//  in       in         data_byte                    in_valid / in_ready
//  out      out        packet_kind .. last          out_valid / out_ready
//  cfg      in         cfg_index, cfg_data          cfg_valid / cfg_ready
//
//  While in_ready is high, one input word per cycle is decoded in a single pass into
//  the result queue. A word causes zero, one or two results; while out_ready is high
//  the output side gives one per cycle, so a run closed by a line marker gives two in turn.
//  in_ready drops while the four-entry result queue holds more than two results.
//  cfg_ready is always high. Reset clears the decoder state and the queue and
//  loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_sprite_packet_decoder_unit #(
	parameter int PIXEL_COUNT_BITS = rsp_pkg::PIXEL_COUNT_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [rsp_pkg::BYTE_W-1:0]          data_byte,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [2:0]                               packet_kind,
	output logic [rsp_pkg::RUN_W-1:0]                run_length,
	output logic [rsp_pkg::BYTE_W-1:0]               pixel_value,
	output logic                                     image_done,
	output logic                                     last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [rsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [rsp_pkg::LINE_W-1:0]   line_width_q;
	logic [rsp_pkg::TOTAL_W-1:0]  total_pixels_q;
	logic                         in_fire;
	logic                         room;
	rsp_pkg::result_pair_t        pair;
	rsp_pkg::result_t             head;

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign in_fire   = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= rsp_pkg::LINE_WIDTH_RST;
			total_pixels_q <= rsp_pkg::TOTAL_PIXELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rsp_pkg::CFG_LINE_WIDTH: begin
					line_width_q <= cfg_data[rsp_pkg::LINE_W-1:0];
				end
				rsp_pkg::CFG_TOTAL_PIXELS: begin
					total_pixels_q <= cfg_data[rsp_pkg::TOTAL_W-1:0];
				end
				default: begin
					line_width_q <= line_width_q;
				end
			endcase
		end
	end

	rsp_decode #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.data_byte    (data_byte),
		.line_width   (line_width_q),
		.total_pixels (total_pixels_q),
		.res          (pair)
	);

	rsp_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pair),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// Drive the result word
	assign packet_kind = head.kind;
	assign run_length  = head.run_length;
	assign pixel_value = head.pixel_value;
	assign image_done  = head.image_done;
	assign last        = head.last;

endmodule

`default_nettype wire

/* hdl/rsp_port_checker.sv */
// ----------------------------------------------------------------------------
// RLE sprite packet decoder - port checker
// Watches the top-level ports for packet-format and stall slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rle_sprite_packet_decoder_unit_defines.svh"

module rsp_port_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic [rsp_pkg::BYTE_W-1:0]        data_byte,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [2:0]                        packet_kind,
	input wire logic [rsp_pkg::RUN_W-1:0]         run_length,
	input wire logic [rsp_pkg::BYTE_W-1:0]        pixel_value,
	input wire logic                              image_done,
	input wire logic                              last
);

	// Hold a stalled input word
	`RSP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(data_byte), "stalled input word changed")

	// Hold a stalled result word
	`RSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(packet_kind) && $stable(run_length) && $stable(pixel_value) && $stable(last), "stalled result word changed")

	// Run packets carry a nonzero length
	`RSP_ASSERT_IMPL(a_run_len, out_valid && (packet_kind == rsp_pkg::KIND_SKIP || packet_kind == rsp_pkg::KIND_SOLID || packet_kind == rsp_pkg::KIND_COPY), run_length != '0, "run packet with zero length")

	// A line marker always closes its byte
	`RSP_ASSERT_IMPL(a_next_last, out_valid && packet_kind == rsp_pkg::KIND_NEXT, last && run_length == '0 && pixel_value == '0, "bad next-line marker")

	// A copy start never reports done
	`RSP_ASSERT_IMPL(a_copy_start, out_valid && packet_kind == rsp_pkg::KIND_COPY, last && !image_done && pixel_value == '0, "bad copy-run start")

endmodule

bind rle_sprite_packet_decoder_unit rsp_port_checker u_port_checker (.*);

`default_nettype wire
